>>> design/bspd_pkg.sv
// ============================================================================
// bspd_pkg
// shared types, codes and pixel conversion for the bmp stream pixel decoder
// ============================================================================
package bspd_pkg;

	// output pixel format codes
	localparam logic [1:0] FMT_RGB24  = 2'd0;
	localparam logic [1:0] FMT_XRGB32 = 2'd1;
	localparam logic [1:0] FMT_RGB565 = 2'd2;

	// result status codes
	localparam logic [1:0] ST_PIXEL     = 2'd0;
	localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
	localparam logic [1:0] ST_BAD_DEPTH = 2'd2;
	localparam logic [1:0] ST_BAD_SIZE  = 2'd3;

	// one accepted input beat
	typedef struct packed {
		logic [7:0] file_byte;
		logic       start_of_file;
	} in_beat_t;

	// one result item
	typedef struct packed {
		logic [31:0] pixel_value;
		logic [11:0] column;
		logic [11:0] row;
		logic [1:0]  status;
		logic        last_pixel;
	} res_t;

	// red high, blue low; unused code 3 behaves as xrgb
	function automatic logic [31:0] to_pixel(
		input logic [1:0] fmt,
		input logic [7:0] r,
		input logic [7:0] g,
		input logic [7:0] b
	);
		logic [31:0] v;
		if (fmt == FMT_RGB565) begin
			v = {16'd0, r[7:3], g[7:2], b[7:3]};
		end else begin
			v = {8'd0, r, g, b};
		end
		return v;
	endfunction

endpackage

>>> design/bspd_in_reg.sv
// ============================================================================
// bspd_in_reg
// input register stage: holds one accepted beat until the parser takes it
// ============================================================================
module bspd_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  bspd_pkg::in_beat_t beat,
	input  logic               adv,
	output logic               step,
	output bspd_pkg::in_beat_t beat_s1
);

	logic v_s1;

	assign step     = v_s1 & adv;
	assign s_tready = ~v_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (step) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			beat_s1 <= beat;
		end
	end

endmodule

>>> design/bspd_parser.sv
// ============================================================================
// bspd_parser
// header capture, skip, pixel gathering and row padding state machine
// ============================================================================
module bspd_parser #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  bspd_pkg::in_beat_t beat_s1,
	input  logic [1:0]         out_format,
	output bspd_pkg::res_t     res,
	output logic               res_valid
);

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 1);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_SKIP   = 3'd1;
	localparam logic [2:0] PH_PIXEL  = 3'd2;
	localparam logic [2:0] PH_PAD    = 3'd3;
	localparam logic [2:0] PH_HALT   = 3'd4;

	localparam logic [7:0]  MAGIC_B     = 8'h42;
	localparam logic [7:0]  MAGIC_M     = 8'h4d;
	localparam logic [15:0] DEPTH_24    = 16'd24;
	localparam logic [31:0] MIN_OFFSET  = 32'd54;

	logic [31:0]   pos_q, off_q, width_q, height_q;
	logic [7:0]    depth_lo_q, magic_q, blue_q, green_q;
	logic [2:0]    phase_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [1:0]    bip_q, pad_q;

	logic [31:0]   c_pos, c_off, c_width, c_height;
	logic [7:0]    c_depth_lo, c_magic, c_blue, c_green;
	logic [2:0]    c_phase;
	logic [CW-1:0] c_col;
	logic [RW-1:0] c_row;
	logic [1:0]    c_bip, c_pad;

	logic [31:0]   n_pos, n_off, n_width, n_height;
	logic [7:0]    n_depth_lo, n_magic, n_blue, n_green;
	logic [2:0]    n_phase;
	logic [CW-1:0] n_col;
	logic [RW-1:0] n_row;
	logic [1:0]    n_bip, n_pad;

	logic [7:0]    b;
	logic [1:0]    lane;
	logic          do_pix, last_col, last_row, size_bad;

	assign b    = beat_s1.file_byte;
	// header fields start at 10, 18 and 22, all two mod four
	assign lane = c_pos[1:0] - 2'd2;

	always_comb begin
		// start of file clears the parser before this byte is taken
		if (beat_s1.start_of_file) begin
			c_pos      = '0;
			c_off      = '0;
			c_width    = '0;
			c_height   = '0;
			c_depth_lo = '0;
			c_magic    = '0;
			c_blue     = '0;
			c_green    = '0;
			c_phase    = PH_HEADER;
			c_col      = '0;
			c_row      = '0;
			c_bip      = '0;
			c_pad      = '0;
		end else begin
			c_pos      = pos_q;
			c_off      = off_q;
			c_width    = width_q;
			c_height   = height_q;
			c_depth_lo = depth_lo_q;
			c_magic    = magic_q;
			c_blue     = blue_q;
			c_green    = green_q;
			c_phase    = phase_q;
			c_col      = col_q;
			c_row      = row_q;
			c_bip      = bip_q;
			c_pad      = pad_q;
		end
	end

	always_comb begin
		n_pos      = c_pos;
		n_off      = c_off;
		n_width    = c_width;
		n_height   = c_height;
		n_depth_lo = c_depth_lo;
		n_magic    = c_magic;
		n_blue     = c_blue;
		n_green    = c_green;
		n_phase    = c_phase;
		n_col      = c_col;
		n_row      = c_row;
		n_bip      = c_bip;
		n_pad      = c_pad;
		res        = '0;
		res_valid  = 1'b0;
		do_pix     = 1'b0;
		last_col   = (32'(c_col) + 32'd1) == c_width;
		last_row   = (32'(c_row) + 32'd1) == c_height;
		size_bad   = (c_width == 32'd0) || (c_width > 32'(MAX_WIDTH)) ||
			(c_height == 32'd0) || (c_height > 32'(MAX_HEIGHT)) ||
			(c_off < MIN_OFFSET);

		if (c_phase != PH_HALT) begin
			n_pos = c_pos + 32'd1;
			if (c_phase == PH_HEADER) begin
				if (c_pos == 32'd0) begin
					n_magic = b;
				end else if (c_pos == 32'd1) begin
					if (c_magic != MAGIC_B || b != MAGIC_M) begin
						res.status = bspd_pkg::ST_BAD_MAGIC;
						res_valid  = 1'b1;
						n_phase    = PH_HALT;
					end
				end else if (c_pos >= 32'd10 && c_pos <= 32'd13) begin
					n_off[8*lane +: 8] = b;
				end else if (c_pos >= 32'd18 && c_pos <= 32'd21) begin
					n_width[8*lane +: 8] = b;
				end else if (c_pos >= 32'd22 && c_pos <= 32'd25) begin
					n_height[8*lane +: 8] = b;
				end else if (c_pos == 32'd28) begin
					n_depth_lo = b;
				end else if (c_pos == 32'd29) begin
					res_valid = 1'b1;
					n_phase   = PH_HALT;
					if ({b, c_depth_lo} != DEPTH_24) begin
						res.status = bspd_pkg::ST_BAD_DEPTH;
					end else if (size_bad) begin
						res.status = bspd_pkg::ST_BAD_SIZE;
					end else begin
						res_valid = 1'b0;
						n_phase   = PH_SKIP;
					end
				end
			end else if (c_phase == PH_SKIP) begin
				// the byte at the offset is already the first blue byte
				do_pix = (c_pos == c_off);
			end else if (c_phase == PH_PAD) begin
				n_pad = c_pad - 2'd1;
				if (n_pad == 2'd0) begin
					n_phase = PH_PIXEL;
				end
			end else begin
				do_pix = 1'b1;
			end

			if (do_pix) begin
				n_phase = PH_PIXEL;
				unique case (c_bip)
					2'd0: begin
						n_blue = b;
						n_bip  = 2'd1;
					end
					2'd1: begin
						n_green = b;
						n_bip   = 2'd2;
					end
					default: begin
						n_bip           = 2'd0;
						res.pixel_value = bspd_pkg::to_pixel(out_format, b, c_green, c_blue);
						res.column      = 12'(c_col);
						res.row         = 12'(c_height) - 12'd1 - 12'(c_row);
						res.status      = bspd_pkg::ST_PIXEL;
						res.last_pixel  = last_col & last_row;
						res_valid       = 1'b1;
						if (last_col) begin
							n_col = '0;
							if (last_row) begin
								n_phase = PH_HALT;
							end else begin
								n_row = c_row + RW'(1);
								// padding to four bytes is width mod four
								n_pad = c_width[1:0];
								if (c_width[1:0] != 2'd0) begin
									n_phase = PH_PAD;
								end
							end
						end else begin
							n_col = c_col + CW'(1);
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			off_q      <= '0;
			width_q    <= '0;
			height_q   <= '0;
			depth_lo_q <= '0;
			magic_q    <= '0;
			blue_q     <= '0;
			green_q    <= '0;
			phase_q    <= PH_HEADER;
			col_q      <= '0;
			row_q      <= '0;
			bip_q      <= '0;
			pad_q      <= '0;
		end else if (step) begin
			pos_q      <= n_pos;
			off_q      <= n_off;
			width_q    <= n_width;
			height_q   <= n_height;
			depth_lo_q <= n_depth_lo;
			magic_q    <= n_magic;
			blue_q     <= n_blue;
			green_q    <= n_green;
			phase_q    <= n_phase;
			col_q      <= n_col;
			row_q      <= n_row;
			bip_q      <= n_bip;
			pad_q      <= n_pad;
		end
	end

endmodule

>>> design/bspd_out_reg.sv
// ============================================================================
// bspd_out_reg
// result register: holds one result beat until the sink takes it
// ============================================================================
module bspd_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  bspd_pkg::res_t res,
	input  logic           res_valid,
	output logic           adv,
	output logic           m_tvalid,
	input  logic           m_tready,
	output bspd_pkg::res_t res_s2
);

	assign adv = ~m_tvalid | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (step) begin
			m_tvalid <= res_valid;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_s2 <= res;
		end
	end

endmodule

>>> design/bmp_stream_pixel_decoder.sv
// ============================================================================
// bmp_stream_pixel_decoder
// 24-bit bmp byte stream to pixels with top-down row and column
// ============================================================================
//
// channel | dir | handshake          | content
// --------+-----+--------------------+--------------------------------------
// s_*     | in  | s_tvalid/s_tready  | one file byte per beat, tuser = start
// m_*     | out | m_tvalid/m_tready  | pixel or error beat, tlast = last pixel
// cfg_*   | in  | cfg_valid/cfg_ready| output format register
//
// one file byte per cycle: a byte goes from the input register through the
// parser logic into the result register, so a beat is accepted every cycle
// while the result register is empty or being drained.
// a stalled sink holds one result and one byte; further input waits.
// reset clears the parser to byte 0 of a file and sets the format to xrgb.
// after an error or the final pixel bytes are dropped until a start beat.
// ============================================================================
module bmp_stream_pixel_decoder #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] file_byte
	input  logic        s_tuser,   // [0] start_of_file
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [31:0] pixel_value, [43:32] column, [55:44] row
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast,   // last_pixel
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data   // out_format
);

	bspd_pkg::in_beat_t beat, beat_s1;
	bspd_pkg::res_t     res, res_s2;
	logic               res_valid, step, adv;
	logic [1:0]         fmt_q;

	// format register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= bspd_pkg::FMT_XRGB32;
		end else if (cfg_valid && cfg_ready) begin
			fmt_q <= cfg_data;
		end
	end

	assign beat.file_byte     = s_tdata;
	assign beat.start_of_file = s_tuser;

	// input register stage
	bspd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.beat     (beat),
		.adv      (adv),
		.step     (step),
		.beat_s1  (beat_s1)
	);

	// parser state and per-byte decision
	bspd_parser #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.beat_s1    (beat_s1),
		.out_format (fmt_q),
		.res        (res),
		.res_valid  (res_valid)
	);

	// result register stage
	bspd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.res       (res),
		.res_valid (res_valid),
		.adv       (adv),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res_s2    (res_s2)
	);

	// pack result fields, first field lowest
	assign m_tdata = {res_s2.row, res_s2.column, res_s2.pixel_value};
	assign m_tuser = res_s2.status;
	assign m_tlast = res_s2.last_pixel;

endmodule

>>> dv/bspd_tb_pkg.sv
`timescale 1ns / 100ps
// ============================================================================
// bspd_tb_pkg
// parser predictor and in-order result scoreboard for the bmp stream decoder
// ============================================================================
package bspd_tb_pkg;

	import bspd_pkg::*;

	localparam logic [7:0]  MAGIC_B   = 8'h42;
	localparam logic [7:0]  MAGIC_M   = 8'h4D;
	localparam logic [15:0] BPP_24    = 16'd24;
	localparam int unsigned HDR_BYTES = 54;
	localparam int unsigned OFS_POS   = 10;
	localparam int unsigned WID_POS   = 18;
	localparam int unsigned HGT_POS   = 22;
	localparam int unsigned BPP_POS   = 28;

	typedef enum logic [2:0] {P_HEADER, P_SKIP, P_PIXEL, P_PAD, P_HALT} parse_phase_e;

	class pixel_scoreboard;
		int unsigned  max_w;
		int unsigned  max_h;
		logic [1:0]   out_format;
		int unsigned  mismatches;
		res_t         expected_pixels[$];

		// parser copy
		parse_phase_e ph;
		int unsigned  pos;
		int unsigned  offs;
		int unsigned  wid;
		int unsigned  hgt;
		logic [15:0]  depth;
		logic [7:0]   magic0;
		int unsigned  col;
		int unsigned  rown;
		int unsigned  lane;
		logic [7:0]   blue;
		logic [7:0]   green;
		int unsigned  pad;

		function new(int unsigned mw, int unsigned mh);
			max_w = mw;
			max_h = mh;
			out_format = FMT_XRGB32;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			ph = P_HEADER;
			pos = 0;
			offs = 0;
			wid = 0;
			hgt = 0;
			depth = '0;
			magic0 = '0;
			col = 0;
			rown = 0;
			lane = 0;
			blue = '0;
			green = '0;
			pad = 0;
		endfunction

		function int unsigned outstanding();
			return expected_pixels.size();
		endfunction

		function void push_error(logic [1:0] code);
			res_t r;
			r = '0;
			r.status = code;
			expected_pixels.push_back(r);
			ph = P_HALT;
		endfunction

		// returns 1 when the byte was not dropped by a halted parser
		function bit note_byte(logic [7:0] b, logic sof);
			int unsigned p;
			res_t r;
			bit last_col;
			bit last_row;
			if (sof) restart();
			if (ph == P_HALT) return 1'b0;
			p = pos;
			pos = pos + 1;
			if (ph == P_HEADER) begin
				if (p == 0) begin
					magic0 = b;
				end else if (p == 1) begin
					if (magic0 != MAGIC_B || b != MAGIC_M) push_error(ST_BAD_MAGIC);
				end else if (p >= OFS_POS && p < OFS_POS + 4) begin
					offs |= 32'(b) << (8 * (p - OFS_POS));
				end else if (p >= WID_POS && p < WID_POS + 4) begin
					wid |= 32'(b) << (8 * (p - WID_POS));
				end else if (p >= HGT_POS && p < HGT_POS + 4) begin
					hgt |= 32'(b) << (8 * (p - HGT_POS));
				end else if (p == BPP_POS) begin
					depth = {8'h00, b};
				end else if (p == BPP_POS + 1) begin
					depth[15:8] = b;
					if (depth != BPP_24) begin
						push_error(ST_BAD_DEPTH);
					end else if (wid == 0 || wid > max_w || hgt == 0 || hgt > max_h ||
							offs < HDR_BYTES) begin
						push_error(ST_BAD_SIZE);
					end else begin
						ph = P_SKIP;
					end
				end
				return 1'b1;
			end
			if (ph == P_SKIP) begin
				if (p != offs) return 1'b1;
				ph = P_PIXEL;
			end
			if (ph == P_PAD) begin
				pad = (pad - 1) & 3;
				if (pad == 0) ph = P_PIXEL;
				return 1'b1;
			end
			if (lane == 0) begin
				blue = b;
				lane = 1;
				return 1'b1;
			end
			if (lane == 1) begin
				green = b;
				lane = 2;
				return 1'b1;
			end
			lane = 0;
			last_col = (col + 1 == wid);
			last_row = (rown + 1 == hgt);
			r = '0;
			if (out_format == FMT_RGB565) begin
				r.pixel_value = {16'd0, b[7:3], green[7:2], blue[7:3]};
			end else begin
				r.pixel_value = {8'd0, b, green, blue};
			end
			r.column = col[11:0];
			r.row = 12'(hgt - 1 - rown);
			r.status = ST_PIXEL;
			r.last_pixel = last_col && last_row;
			expected_pixels.push_back(r);
			if (last_col) begin
				col = 0;
				if (last_row) begin
					ph = P_HALT;
				end else begin
					rown = rown + 1;
					pad = (0 - wid * 3) & 3;
					if (pad != 0) ph = P_PAD;
				end
			end else begin
				col = col + 1;
			end
			return 1'b1;
		endfunction

		function void check_pixel(res_t got);
			res_t want;
			if (expected_pixels.size() == 0) begin
				$error("unexpected result beat: status %0d value %h", got.status,
					got.pixel_value);
				mismatches++;
				return;
			end
			want = expected_pixels.pop_front();
			if (got.pixel_value !== want.pixel_value) begin
				$error("pixel_value: expected %h, got %h", want.pixel_value, got.pixel_value);
				mismatches++;
			end
			if (got.column !== want.column) begin
				$error("column: expected %0d, got %0d", want.column, got.column);
				mismatches++;
			end
			if (got.row !== want.row) begin
				$error("row: expected %0d, got %0d", want.row, got.row);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.last_pixel !== want.last_pixel) begin
				$error("last_pixel: expected %0d, got %0d", want.last_pixel, got.last_pixel);
				mismatches++;
			end
		endfunction
	endclass

endpackage

>>> dv/tb_bmp_stream_pixel_decoder.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_bmp_stream_pixel_decoder
// feeds bmp files byte by byte, whole, cut short and broken ones, under random
// source gaps and sink stalls, and checks every pixel and error beat in order
// against a byte-level parser model kept in the scoreboard
// ============================================================================
module tb_bmp_stream_pixel_decoder;

	import bspd_pkg::*;
	import bspd_tb_pkg::*;

	localparam int unsigned MAX_W        = 4096;
	localparam int unsigned MAX_H        = 4096;
	localparam int unsigned CYCLE_LIMIT  = 2_000_000;
	localparam int unsigned ITEM_COUNT   = 1400;
	localparam int unsigned IDLE_CYCLES  = 8;    // covers the input and result registers and more
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam logic [1:0]  FMT_UNUSED   = 2'd3;

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] file_byte
	logic        s_tuser;    // [0] start_of_file
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;    // [31:0] pixel_value, [43:32] column, [55:44] row
	logic [1:0]  m_tuser;    // [1:0] status
	logic        m_tlast;    // last_pixel
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_data;   // out_format

	pixel_scoreboard sb = new(MAX_W, MAX_H);
	bit              full_rate = 1'b0;   // no gaps on either side while set
	int unsigned     cycles = 0;
	int unsigned     sent_bytes = 0;     // accepted input beats
	logic [7:0]      file_bytes[$];      // file under construction

	bmp_stream_pixel_decoder #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run-length guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// every accepted result beat goes to the scoreboard; values seen here are
	// the ones from before the edge
	always @(posedge clk) begin : watch_results
		res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.pixel_value = m_tdata[31:0];
			got.column = m_tdata[43:32];
			got.row = m_tdata[55:44];
			got.status = m_tuser;
			got.last_pixel = m_tlast;
			sb.check_pixel(got);
		end
	end

	// mostly short gaps, now and then a long one, none while full_rate is set
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (full_rate) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 94) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// sink: bursts of ready broken by stalls
	initial begin : sink_side
		int unsigned stall;
		m_tready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = pick_gap();
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// one file byte beat; valid stays up after the handshake so that the next
	// byte can follow in the very next cycle
	task automatic send_byte(input logic [7:0] b, input logic sof);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= sof;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		void'(sb.note_byte(b, sof));
		sent_bytes++;
	endtask

	// stop the source and hold off until every expected beat is out and the
	// pipe has had time to settle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_format(input logic [1:0] fmt);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= fmt;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.out_format = fmt;
	endtask

	// header with random filler, then for a well-formed header the gap up to
	// the pixel offset and the padded pixel rows, then junk bytes
	function automatic void build_file(input int unsigned w, input int unsigned h,
			input int unsigned offs, input logic [15:0] bpp, input logic [7:0] m0,
			input logic [7:0] m1, input fill_e fill, input int unsigned junk);
		bit good;
		int unsigned row_bytes;
		file_bytes.delete();
		for (int i = 0; i < HDR_BYTES; i++) file_bytes.push_back(8'($urandom));
		file_bytes[0] = m0;
		file_bytes[1] = m1;
		for (int i = 0; i < 4; i++) begin
			file_bytes[OFS_POS + i] = offs[8 * i +: 8];
			file_bytes[WID_POS + i] = w[8 * i +: 8];
			file_bytes[HGT_POS + i] = h[8 * i +: 8];
		end
		file_bytes[BPP_POS] = bpp[7:0];
		file_bytes[BPP_POS + 1] = bpp[15:8];
		good = m0 == MAGIC_B && m1 == MAGIC_M && bpp == BPP_24 && w != 0 && w <= MAX_W &&
			h != 0 && h <= MAX_H && offs >= HDR_BYTES;
		if (good) begin
			while (file_bytes.size() < offs) file_bytes.push_back(8'($urandom));
			row_bytes = (w * 3 + 3) & ~32'd3;
			for (int unsigned r = 0; r < h; r++) begin
				for (int unsigned c = 0; c < row_bytes; c++) begin
					if (c >= w * 3 || fill == FILL_RANDOM) file_bytes.push_back(8'($urandom));
					else file_bytes.push_back((fill == FILL_ONES) ? 8'hFF : 8'h00);
				end
			end
		end
		for (int unsigned i = 0; i < junk; i++) file_bytes.push_back(8'($urandom));
	endfunction

	// cut = 0 sends the whole file, otherwise only its first cut bytes
	task automatic send_file(input bit mark, input int unsigned cut);
		int unsigned n;
		n = (cut != 0 && cut < file_bytes.size()) ? cut : file_bytes.size();
		for (int unsigned i = 0; i < n; i++) send_byte(file_bytes[i], mark && i == 0);
	endtask

	task automatic good_file(input int unsigned w, input int unsigned h,
			input int unsigned offs, input fill_e fill, input int unsigned junk);
		build_file(w, h, offs, BPP_24, MAGIC_B, MAGIC_M, fill, junk);
		send_file(1'b1, 0);
	endtask

	// a bad header is decided by byte 29 at the latest, so only the header
	// start and a few dropped bytes after it go out
	task automatic bad_file(input int unsigned w, input int unsigned h,
			input int unsigned offs, input logic [15:0] bpp, input logic [7:0] m0,
			input logic [7:0] m1);
		int unsigned cut;
		build_file(w, h, offs, bpp, m0, m1, FILL_RANDOM, 0);
		cut = (m0 == MAGIC_B && m1 == MAGIC_M) ? BPP_POS + 2 : 2;
		send_file(1'b1, cut + $urandom_range(0, 4));
	endtask

	// random bytes; with marks some of them restart the parser
	task automatic send_noise(input int unsigned n, input bit marks);
		for (int unsigned i = 0; i < n; i++)
			send_byte(8'($urandom), marks && $urandom_range(0, 7) == 0);
	endtask

	initial begin : stimulus
		int unsigned roll;
		int unsigned kind;
		int unsigned w;
		int unsigned h;
		int unsigned offs;
		logic [15:0] bpp;
		logic [7:0]  m0;
		logic [7:0]  m1;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed, format at its reset value (xrgb) ----
		// no start mark: the parser already sits at byte 0 after reset
		build_file(1, 1, HDR_BYTES, BPP_24, MAGIC_B, MAGIC_M, FILL_RANDOM, 0);
		send_file(1'b0, 0);
		// bytes after the final pixel are dropped
		send_noise(3, 1'b0);
		// every padding length (1, 2, 3, 0 bytes per row), skip gap, pixel extremes
		good_file(1, 2, HDR_BYTES, FILL_ONES, 0);
		good_file(2, 2, HDR_BYTES + 3, FILL_ZERO, 0);
		good_file(3, 2, HDR_BYTES + 6, FILL_RANDOM, 0);
		good_file(4, 2, HDR_BYTES, FILL_RANDOM, 5);
		// bad magic in either byte or both
		bad_file(1, 1, HDR_BYTES, BPP_24, MAGIC_M, MAGIC_B);
		bad_file(1, 1, HDR_BYTES, BPP_24, MAGIC_B, 8'h00);
		bad_file(1, 1, HDR_BYTES, BPP_24, 8'hFF, MAGIC_M);
		// wrong depth, in the low and the high byte; depth wins over size
		bad_file(2, 2, HDR_BYTES, 16'd32, MAGIC_B, MAGIC_M);
		bad_file(2, 2, HDR_BYTES, BPP_24 | 16'h0100, MAGIC_B, MAGIC_M);
		bad_file(0, 0, 0, 16'd8, MAGIC_B, MAGIC_M);
		// size and offset limits
		bad_file(0, 2, HDR_BYTES, BPP_24, MAGIC_B, MAGIC_M);
		bad_file(MAX_W + 1, 2, HDR_BYTES, BPP_24, MAGIC_B, MAGIC_M);
		bad_file(2, 0, HDR_BYTES, BPP_24, MAGIC_B, MAGIC_M);
		bad_file(2, MAX_H + 1, HDR_BYTES, BPP_24, MAGIC_B, MAGIC_M);
		bad_file(2, 2, HDR_BYTES - 1, BPP_24, MAGIC_B, MAGIC_M);
		bad_file(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, BPP_24, MAGIC_B, MAGIC_M);
		// start mark in the middle of a header and of the pixel data
		build_file(3, 3, HDR_BYTES, BPP_24, MAGIC_B, MAGIC_M, FILL_RANDOM, 0);
		send_file(1'b1, 20);
		build_file(3, 3, HDR_BYTES, BPP_24, MAGIC_B, MAGIC_M, FILL_RANDOM, 0);
		send_file(1'b1, HDR_BYTES + 17);
		good_file(2, 1, HDR_BYTES, FILL_RANDOM, 0);
		// largest width and height are accepted; first pixels only, at full rate
		full_rate = 1'b1;
		build_file(MAX_W, 1, HDR_BYTES, BPP_24, MAGIC_B, MAGIC_M, FILL_RANDOM, 0);
		send_file(1'b1, HDR_BYTES + 9);
		build_file(1, MAX_H, HDR_BYTES, BPP_24, MAGIC_B, MAGIC_M, FILL_RANDOM, 0);
		send_file(1'b1, HDR_BYTES + 9);
		full_rate = 1'b0;
		// every format code, the unused one included
		write_format(FMT_RGB24);
		good_file(3, 2, HDR_BYTES, FILL_ONES, 0);
		write_format(FMT_RGB565);
		good_file(3, 2, HDR_BYTES, FILL_ONES, 0);
		write_format(FMT_UNUSED);
		good_file(2, 1, HDR_BYTES, FILL_RANDOM, 0);
		write_format(FMT_XRGB32);

		// ---- random files, mostly well formed ----
		while (sent_bytes < ITEM_COUNT) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) write_format(2'($urandom_range(0, 3)));
			else if (roll < 12) drain_results();
			full_rate = ($urandom_range(0, 5) == 0);
			kind = $urandom_range(0, 99);
			w = $urandom_range(1, 6);
			h = $urandom_range(1, 4);
			offs = HDR_BYTES + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
			if (kind < 64) begin
				good_file(w, h, offs, FILL_RANDOM, $urandom_range(0, 1) * $urandom_range(1, 4));
			end else if (kind < 72) begin
				m0 = ($urandom_range(0, 1) == 0) ? MAGIC_B : 8'($urandom);
				m1 = ($urandom_range(0, 1) == 0) ? MAGIC_M : 8'($urandom);
				if (m0 == MAGIC_B && m1 == MAGIC_M) m1 = ~MAGIC_M;
				bad_file(w, h, offs, BPP_24, m0, m1);
			end else if (kind < 78) begin
				bpp = 16'($urandom);
				if (bpp == BPP_24) bpp = 16'd32;
				bad_file(w, h, offs, bpp, MAGIC_B, MAGIC_M);
			end else if (kind < 86) begin
				case ($urandom_range(0, 4))
					0: w = 0;
					1: w = MAX_W + 1 + $urandom_range(0, 1) * $urandom;
					2: h = 0;
					3: h = MAX_H + 1 + $urandom_range(0, 1) * $urandom;
					default: offs = $urandom_range(0, HDR_BYTES - 1);
				endcase
				bad_file(w, h, offs, BPP_24, MAGIC_B, MAGIC_M);
			end else if (kind < 94) begin
				// cut short, the next start mark abandons it
				build_file(w, h, offs, BPP_24, MAGIC_B, MAGIC_M, FILL_RANDOM, 0);
				send_file(1'b1, $urandom_range(1, file_bytes.size() - 1));
			end else begin
				send_noise($urandom_range(1, 12), 1'b1);
			end
		end

		// ---- wind down ----
		full_rate = 1'b0;
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
